// File: hw/rtl/byte_stack_palindrome_check_top_macros.svh
// Assertion macros for the byte stack block.
// Used by the port-level checker; depends on clk_i and rst_ni in scope.
`ifndef BYTE_STACK_PALINDROME_CHECK_TOP_MACROS_SVH
`define BYTE_STACK_PALINDROME_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bspc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bspc: next-cycle check failed");

`endif

// File: hw/rtl/bspc_pkg.sv
// Shared types and sizing constants for the byte stack block.
// No dependencies; imported by the top level and the checker.
`default_nettype none
package bspc_pkg;

  localparam int StackDepth = 32;
  localparam int AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int CountW     = $clog2(StackDepth + 1);
  localparam int ByteW      = 8;
  localparam int ModeW      = 2;
  localparam int DepthOutW  = 6;
  localparam int StatusW    = 2;

  typedef enum logic [ModeW-1:0] {
    ModePush  = 2'd0,
    ModePop   = 2'd1,
    ModeCheck = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StatOk       = 2'd0,
    StatPushFull = 2'd1,
    StatPopEmpty = 2'd2
  } status_e;

endpackage
`default_nettype wire

// File: hw/rtl/bspc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bspc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/byte_stack_palindrome_check_top.sv
// Byte stack top level: sequencer, fill count and two mirrored stack RAMs.
// Depends on bspc_pkg and bspc_ram.
`default_nettype none
// Bounded LIFO of bytes. An item (mode_i, push_byte_i) is taken when start is high
// and busy is low; its result appears for one cycle with valid_o high and cannot be
// held off. Push, a rejected op, a pop of the last byte, a check of fewer than two
// bytes and the unused mode give their result the cycle after the item is taken. A
// pop that leaves bytes behind goes through StPopRd, since the new top byte is fetched
// from the RAM, whose read data is registered. A longer palindrome check walks in
// StChk: one entry pair is compared per cycle, read through two mirrored RAM copies,
// and the walk ends early on the first mismatch. busy is high while in StPopRd or
// StChk. No clearing pass is needed after reset.
module byte_stack_palindrome_check_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bspc_pkg::ModeW-1:0]    mode_i,
  input  wire logic [bspc_pkg::ByteW-1:0]    push_byte_i,
  output logic                               valid_o,
  output logic [bspc_pkg::ByteW-1:0]         top_byte_o,
  output logic [bspc_pkg::DepthOutW-1:0]     depth_used_o,
  output logic                               is_empty_o,
  output logic                               is_full_o,
  output logic                               is_palindrome_o,
  output logic [bspc_pkg::StatusW-1:0]       status_o
);
  import bspc_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StPopRd,
    StChk
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [ByteW-1:0]    top_q, top_d;
  logic [AddrW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic                valid_q, valid_d;
  logic                pal_q, pal_d;
  status_e             status_q, status_d;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr, rd_addr_a, rd_addr_b;
  logic [ByteW-1:0]    rd_data_a, rd_data_b;
  logic                empty, full;
  logic [AddrW:0]      span;

  assign empty = (count_q == '0);
  assign full  = (count_q == CountW'(StackDepth));
  assign span  = {1'b0, hi_q} - {1'b0, lo_q};

  assign ram_waddr = count_q[AddrW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    top_d     = top_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    valid_d   = 1'b0;
    pal_d     = 1'b0;
    status_d  = StatOk;
    ram_we    = 1'b0;
    rd_addr_a = lo_q;
    rd_addr_b = hi_q;

    case (state_q)
      StIdle: begin
        if (start) begin
          case (mode_e'(mode_i))
            ModePush: begin
              valid_d = 1'b1;
              if (full) begin
                status_d = StatPushFull;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CountW'(1);
                top_d   = push_byte_i;
              end
            end
            ModePop: begin
              if (empty) begin
                valid_d  = 1'b1;
                status_d = StatPopEmpty;
              end else begin
                count_d = count_q - CountW'(1);
                if (count_q == CountW'(1)) begin
                  valid_d = 1'b1;
                  top_d   = '0;
                end else begin
                  // fetch the byte that becomes the new top
                  rd_addr_a = AddrW'(count_q - CountW'(2));
                  state_d   = StPopRd;
                end
              end
            end
            ModeCheck: begin
              if (count_q <= CountW'(1)) begin
                valid_d = 1'b1;
                pal_d   = 1'b1;
              end else begin
                lo_d      = '0;
                hi_d      = AddrW'(count_q - CountW'(1));
                rd_addr_a = '0;
                rd_addr_b = AddrW'(count_q - CountW'(1));
                state_d   = StChk;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      StPopRd: begin
        top_d   = rd_data_a;
        valid_d = 1'b1;
        state_d = StIdle;
      end
      StChk: begin
        // RAM outputs hold entries lo_q and hi_q
        if (rd_data_a != rd_data_b) begin
          valid_d = 1'b1;
          state_d = StIdle;
        end else if (span <= (AddrW+1)'(2)) begin
          valid_d = 1'b1;
          pal_d   = 1'b1;
          state_d = StIdle;
        end else begin
          lo_d      = lo_q + AddrW'(1);
          hi_d      = hi_q - AddrW'(1);
          rd_addr_a = lo_q + AddrW'(1);
          rd_addr_b = hi_q - AddrW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      top_q    <= '0;
      valid_q  <= 1'b0;
      pal_q    <= 1'b0;
      status_q <= StatOk;
      lo_q     <= '0;
      hi_q     <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      top_q    <= top_d;
      valid_q  <= valid_d;
      pal_q    <= pal_d;
      status_q <= status_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
    end
  end

  bspc_ram #(
    .Width(ByteW),
    .Depth(StackDepth)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_byte_i),
    .raddr_i(rd_addr_a),
    .rdata_o(rd_data_a)
  );

  // mirror copy: second read port for the palindrome walk
  bspc_ram #(
    .Width(ByteW),
    .Depth(StackDepth)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_byte_i),
    .raddr_i(rd_addr_b),
    .rdata_o(rd_data_b)
  );

  assign busy            = (state_q != StIdle);
  assign valid_o         = valid_q;
  assign top_byte_o      = top_q;
  assign depth_used_o    = DepthOutW'(count_q);
  assign is_empty_o      = empty;
  assign is_full_o       = full;
  assign is_palindrome_o = pal_q;
  assign status_o        = status_q;

endmodule
`default_nettype wire

// File: hw/rtl/bspc_checker.sv
// Port-level checker for the byte stack block, bound to the top level.
// Depends on bspc_pkg and byte_stack_palindrome_check_top_macros.svh.
`default_nettype none
`include "byte_stack_palindrome_check_top_macros.svh"
module bspc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          valid_o,
  input wire logic [bspc_pkg::ByteW-1:0]    top_byte_o,
  input wire logic [bspc_pkg::DepthOutW-1:0] depth_used_o,
  input wire logic                          is_empty_o,
  input wire logic                          is_full_o,
  input wire logic                          is_palindrome_o,
  input wire logic [bspc_pkg::StatusW-1:0]  status_o
);
  import bspc_pkg::*;

  // an empty stack shows a zero top byte
  `BSPC_ASSERT_NOW(a_empty_top_zero, valid_o && is_empty_o, top_byte_o == '0)
  // a rejected push only happens on a full stack, a rejected pop on an empty one
  `BSPC_ASSERT_NOW(a_push_rej_full, valid_o && (status_o == StatPushFull), is_full_o)
  `BSPC_ASSERT_NOW(a_pop_rej_empty, valid_o && (status_o == StatPopEmpty), is_empty_o)
  // a passing check is never a rejected op
  `BSPC_ASSERT_NOW(a_pal_ok, valid_o && is_palindrome_o, status_o == StatOk)
  // while busy, no new item is taken, so a result must still be owed
  `BSPC_ASSERT_NEXT(a_busy_ends_in_result, busy && !valid_o && start, busy || valid_o)

endmodule

bind byte_stack_palindrome_check_top bspc_checker u_bspc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .valid_o        (valid_o),
  .top_byte_o     (top_byte_o),
  .depth_used_o   (depth_used_o),
  .is_empty_o     (is_empty_o),
  .is_full_o      (is_full_o),
  .is_palindrome_o(is_palindrome_o),
  .status_o       (status_o)
);
`default_nettype wire
